@@ src/assert_macros.svh @@
// Assertion macros shared by the timer table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define MSTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a condition in the next.
`define MSTT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ src/mstt_pkg.sv @@
// Types and constants shared by the timer table modules.
`timescale 1ns / 1ps
`default_nettype none
package mstt_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int RES_CNT_W      = $clog2(MAX_RESULTS);
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = QPTR_W + 1;

    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_DELETE  = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;
    localparam logic [2:0] OP_SERVICE = 3'd5;

    localparam logic [1:0] MODE_ONE_SHOT      = 2'd0;
    localparam logic [1:0] MODE_PERIODIC      = 2'd1;
    localparam logic [1:0] MODE_ONE_SHOT_KEEP = 2'd2;

    typedef enum logic [2:0] {
        K_CREATE, K_START, K_STOP, K_DELETE, K_TICK, K_SERVICE
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_NOT_EXIST = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RUN_STOPPED = 2'd0,
        RUN_RUNNING = 2'd1,
        RUN_PENDING = 2'd2
    } t_run;

    typedef enum logic [2:0] {
        B_IDLE, B_OP, B_CRT, B_TRD, B_TWR, B_SRD, B_SWR
    } t_bstate;

    typedef struct packed {
        t_kind       kind;
        t_status     pre_status;
        logic [6:0]  timer_id;
        logic [1:0]  timer_mode;
        logic [31:0] period;
    } t_cmd;

endpackage
`default_nettype wire

@@ src/mstt_front.sv @@
// Front end: decodes each operation beat and checks the id range.
`timescale 1ns / 1ps
`default_nettype none
module mstt_front
    import mstt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_op,
    input  wire logic [6:0]  i_timer_id,
    input  wire logic [1:0]  i_timer_mode,
    input  wire logic [31:0] i_period,
    output logic             o_push_valid,
    input  wire logic        i_push_ready,
    output t_cmd             o_push_data
);

    logic op_known;

    always_comb begin
        op_known = 1'b1;
        o_push_data.kind = K_TICK;
        case (i_op)
            OP_CREATE:  o_push_data.kind = K_CREATE;
            OP_START:   o_push_data.kind = K_START;
            OP_STOP:    o_push_data.kind = K_STOP;
            OP_DELETE:  o_push_data.kind = K_DELETE;
            OP_TICK:    o_push_data.kind = K_TICK;
            OP_SERVICE: o_push_data.kind = K_SERVICE;
            default:    op_known = 1'b0;
        endcase

        if (i_timer_id == 7'd0) begin
            o_push_data.pre_status = ST_NOT_EXIST;
        end else if (i_timer_id > 7'(NUM_TIMERS)) begin
            o_push_data.pre_status = ST_RANGE;
        end else begin
            o_push_data.pre_status = ST_OK;
        end

        o_push_data.timer_id   = i_timer_id;
        o_push_data.timer_mode = i_timer_mode;
        o_push_data.period     = i_period;
    end

    // Unknown operations are taken and dropped.
    assign o_in_ready   = i_push_ready;
    assign o_push_valid = i_in_valid && op_known;

endmodule
`default_nettype wire

@@ src/mstt_queue.sv @@
// Short command queue between the front end and the slot engine.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mstt_queue
    import mstt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_cmd i_push_data,
    output logic      o_pop_valid,
    input  wire logic i_pop,
    output t_cmd      o_pop_data
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push_fire;
    logic              pop_fire;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push_fire    = i_push_valid && o_push_ready;
    assign pop_fire     = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_fire) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop_fire) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (push_fire && !pop_fire) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop_fire && !push_fire) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    `MSTT_ASSERT(a_q_count_range, r_count <= QCNT_W'(QUEUE_DEPTH), "Queue count beyond depth")
    `MSTT_ASSERT_NEXT(a_q_no_silent_loss, (|r_count) && !pop_fire, |r_count, "Queue lost a beat")
    `MSTT_ASSERT(a_q_ptr_gap, r_wr_ptr == QPTR_W'(r_rd_ptr + QPTR_W'(r_count)), "Bad pointer gap")

endmodule
`default_nettype wire

@@ src/mstt_back.sv @@
// Slot engine: walks the timer slots to carry out each queued command.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mstt_back
    import mstt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    output logic             o_q_pop,
    input  wire t_cmd        i_q_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [6:0]       o_result_id,
    output logic             o_fired,
    output logic             o_last
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    t_bstate               r_state;
    t_bstate               n_state;
    t_cmd                  r_cmd;
    logic [IW-1:0]         r_idx;
    logic [RES_CNT_W-1:0]  r_n;

    logic [NUM_TIMERS-1:0] r_in_use;
    t_run                  r_run [NUM_TIMERS];

    logic [31:0]           r_cnt_mem  [NUM_TIMERS];
    logic [31:0]           r_per_mem  [NUM_TIMERS];
    logic [1:0]            r_mode_mem [NUM_TIMERS];
    logic [31:0]           r_rd_cnt;
    logic [31:0]           r_rd_per;
    logic [1:0]            r_rd_mode;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [6:0]            r_out_id;
    logic                  r_out_fired;
    logic                  r_out_last;

    logic [IW-1:0]         cmd_idx;
    logic                  last_idx;
    logic                  out_free;
    logic [31:0]           cnt_inc;
    logic [NUM_TIMERS-1:0] pend_vec;
    logic [NUM_TIMERS-1:0] above_mask;
    logic [NUM_TIMERS-1:0] free_busy_vec;
    logic                  svc_last;
    logic                  tick_hit;

    logic                  mem_rd;
    logic                  cnt_we;
    logic [31:0]           cnt_wdata;
    logic                  cfg_we;
    logic                  out_load;
    t_status               out_status;
    logic [6:0]            out_id;
    logic                  out_fired;
    logic                  out_last;
    logic                  slot_we;
    logic [IW-1:0]         sl_idx;
    logic                  slot_use;
    t_run                  slot_run;
    logic                  idx_step;
    logic                  n_inc;

    assign cmd_idx  = IW'(r_cmd.timer_id - 7'd1);
    assign last_idx = (r_idx == IW'(NUM_TIMERS - 1));
    assign out_free = !r_out_valid || i_out_ready;
    assign cnt_inc  = (r_rd_cnt == 32'hFFFF_FFFF) ? r_rd_cnt : r_rd_cnt + 32'd1;
    assign tick_hit = r_in_use[r_idx] && (r_run[r_idx] == RUN_RUNNING);

    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            pend_vec[i]      = r_in_use[i] && (r_run[i] == RUN_PENDING);
            above_mask[i]    = (IW'(i) > r_idx);
            free_busy_vec[i] = !r_in_use[i] && (r_run[i] != RUN_STOPPED);
        end
    end

    // The final report of a service beat is the last pending slot or the cap.
    assign svc_last = !(|(pend_vec & above_mask)) ||
                      (r_n == RES_CNT_W'(MAX_RESULTS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_data.kind)
                        K_CREATE:  n_state = B_CRT;
                        K_START:   n_state = B_OP;
                        K_STOP:    n_state = B_OP;
                        K_DELETE:  n_state = B_OP;
                        K_TICK:    n_state = B_TRD;
                        K_SERVICE: n_state = B_SRD;
                        default:   n_state = B_IDLE;
                    endcase
                end
            end
            B_OP: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            B_CRT: begin
                if ((!r_in_use[r_idx] || last_idx) && out_free) begin
                    n_state = B_IDLE;
                end
            end
            B_TRD: begin
                if (tick_hit) begin
                    n_state = B_TWR;
                end else if (last_idx) begin
                    n_state = B_IDLE;
                end
            end
            B_TWR: begin
                n_state = last_idx ? B_IDLE : B_TRD;
            end
            B_SRD: begin
                if (pend_vec[r_idx]) begin
                    n_state = B_SWR;
                end else if (last_idx) begin
                    n_state = B_IDLE;
                end
            end
            B_SWR: begin
                if (out_free) begin
                    n_state = (svc_last || last_idx) ? B_IDLE : B_SRD;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop    = 1'b0;
        mem_rd     = 1'b0;
        cnt_we     = 1'b0;
        cnt_wdata  = 32'd0;
        cfg_we     = 1'b0;
        out_load   = 1'b0;
        out_status = ST_OK;
        out_id     = 7'd0;
        out_fired  = 1'b0;
        out_last   = 1'b1;
        slot_we    = 1'b0;
        sl_idx     = r_idx;
        slot_use   = 1'b0;
        slot_run   = RUN_STOPPED;
        idx_step   = 1'b0;
        n_inc      = 1'b0;
        case (r_state)
            B_IDLE: begin
                o_q_pop = i_q_valid;
            end
            B_OP: begin
                out_load = 1'b1;
                if (r_cmd.pre_status != ST_OK) begin
                    out_status = r_cmd.pre_status;
                end else if (!r_in_use[cmd_idx]) begin
                    out_status = ST_NOT_EXIST;
                end else begin
                    out_status = ST_OK;
                    slot_we    = out_free;
                    sl_idx     = cmd_idx;
                    case (r_cmd.kind)
                        K_START: begin
                            slot_use = 1'b1;
                            slot_run = RUN_RUNNING;
                        end
                        K_STOP: begin
                            slot_use = 1'b1;
                            slot_run = RUN_STOPPED;
                        end
                        default: begin
                            slot_use = 1'b0;
                            slot_run = RUN_STOPPED;
                        end
                    endcase
                end
            end
            B_CRT: begin
                if (!r_in_use[r_idx]) begin
                    out_load  = 1'b1;
                    out_id    = 7'(r_idx) + 7'd1;
                    cfg_we    = out_free;
                    cnt_we    = out_free;
                    slot_we   = out_free;
                    slot_use  = 1'b1;
                    slot_run  = RUN_STOPPED;
                end else if (last_idx) begin
                    out_load   = 1'b1;
                    out_status = ST_NO_FREE;
                end else begin
                    idx_step = 1'b1;
                end
            end
            B_TRD: begin
                if (tick_hit) begin
                    mem_rd = 1'b1;
                end else begin
                    idx_step = 1'b1;
                end
            end
            B_TWR: begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_inc;
                idx_step  = 1'b1;
                if (cnt_inc >= r_rd_per) begin
                    slot_we  = 1'b1;
                    slot_use = 1'b1;
                    slot_run = RUN_PENDING;
                end
            end
            B_SRD: begin
                if (pend_vec[r_idx]) begin
                    mem_rd = 1'b1;
                end else begin
                    idx_step = 1'b1;
                end
            end
            B_SWR: begin
                out_load  = 1'b1;
                out_id    = 7'(r_idx) + 7'd1;
                out_fired = 1'b1;
                out_last  = svc_last;
                idx_step  = out_free;
                n_inc     = out_free;
                case (r_rd_mode)
                    MODE_ONE_SHOT: begin
                        slot_we  = out_free;
                        slot_use = 1'b0;
                        slot_run = RUN_STOPPED;
                    end
                    MODE_PERIODIC: begin
                        cnt_we   = out_free;
                        slot_we  = out_free;
                        slot_use = 1'b1;
                        slot_run = RUN_RUNNING;
                    end
                    MODE_ONE_SHOT_KEEP: begin
                        cnt_we   = out_free;
                        slot_we  = out_free;
                        slot_use = 1'b1;
                        slot_run = RUN_STOPPED;
                    end
                    default: begin
                        slot_we = 1'b0;
                    end
                endcase
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_idx   <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_idx <= '0;
                r_n   <= '0;
            end else begin
                if (idx_step) begin
                    r_idx <= r_idx + IW'(1);
                end
                if (n_inc) begin
                    r_n <= r_n + RES_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_run[i] <= RUN_STOPPED;
            end
        end else if (slot_we) begin
            r_in_use[sl_idx] <= slot_use;
            r_run[sl_idx]    <= slot_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[r_idx] <= cnt_wdata;
        end
        if (cfg_we) begin
            r_per_mem[r_idx]  <= r_cmd.period;
            r_mode_mem[r_idx] <= r_cmd.timer_mode;
        end
        if (mem_rd) begin
            r_rd_cnt  <= r_cnt_mem[r_idx];
            r_rd_per  <= r_per_mem[r_idx];
            r_rd_mode <= r_mode_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && out_free) begin
            r_out_status <= out_status;
            r_out_id     <= out_id;
            r_out_fired  <= out_fired;
            r_out_last   <= out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = 2'(r_out_status);
    assign o_result_id = r_out_id;
    assign o_fired     = r_out_fired;
    assign o_last      = r_out_last;

    `MSTT_ASSERT(a_free_slot_stopped, !(|free_busy_vec), "A free slot is not stopped")
    `MSTT_ASSERT(a_fired_ok, !r_out_valid || !r_out_fired || r_out_status == ST_OK, "Fired not ok")
    `MSTT_ASSERT(a_leave_idle, r_state != B_IDLE || n_state == B_IDLE || i_q_valid, "No command")
    `MSTT_ASSERT_NEXT(a_tick_rw, r_state == B_TRD && mem_rd, r_state == B_TWR, "No tick write")

endmodule
`default_nettype wire

@@ src/multi_slot_timer_table_unit.sv @@
// Top level of the multi-slot timer table.
// Usage: each input beat on i_in_valid / o_in_ready carries one operation
// (create, start, stop, delete, tick or service) in i_op, i_timer_id,
// i_timer_mode and i_period. Result beats leave on o_out_valid / i_out_ready
// with o_status, o_result_id, o_fired and o_last; o_last marks the final beat
// of an operation. Ticks give no beat, and a service with nothing pending
// gives none either.
// Beats enter a four-entry command queue, so the input is taken while the
// slot engine is busy and while a result waits in the output register.
// The slot engine walks the slots in turn and takes no new command until it
// is back in idle: start, stop and delete act on the named slot, create looks
// for the first free slot, and tick and service visit the slots in order.
// A running (tick) or pending (service) slot is read from its count, period
// and mode memory in one state, then written back and, on service, reported.
// A synchronous active-low reset frees every slot, stops every timer and
// empties the queue and the output register; slot memories are not cleared.
// When the receiver stalls, the engine holds at its current slot until the
// output register drains, and the queue fills and then stalls the sender.
`timescale 1ns / 1ps
`default_nettype none
module multi_slot_timer_table_unit
    import mstt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_op,
    input  wire logic [6:0]  i_timer_id,
    input  wire logic [1:0]  i_timer_mode,
    input  wire logic [31:0] i_period,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [6:0]       o_result_id,
    output logic             o_fired,
    output logic             o_last
);

    logic push_valid;
    logic push_ready;
    t_cmd push_data;
    logic pop_valid;
    logic pop;
    t_cmd pop_data;

    mstt_front #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_timer_id   (i_timer_id),
        .i_timer_mode (i_timer_mode),
        .i_period     (i_period),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    mstt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_data   (pop_data)
    );

    mstt_back #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (pop_valid),
        .o_q_pop     (pop),
        .i_q_data    (pop_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_result_id (o_result_id),
        .o_fired     (o_fired),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire
